/* sv/rpbp_pkg.sv */
// Shared types and constants for the raster-to-page bitplane packer.
package rpbp_pkg;

  // Default sizes of the display geometry.
  localparam int DEFAULT_MAX_COLUMNS = 128;
  localparam int DEFAULT_MAX_PAGES   = 8;

  // Rows of pixels that make up one page byte.
  localparam int ROWS_PER_PAGE = 8;

  // Register reset values as written by software.
  localparam int COLUMNS_RESET = 128;
  localparam int PAGES_RESET   = 8;

  // Payload types.
  typedef logic [7:0] pixel_t;
  typedef logic [7:0] page_byte_t;
  typedef logic [7:0] cfg_data_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_COLUMNS = 1'b0,
    CFG_PAGES   = 1'b1
  } cfg_reg_t;

endpackage

/* sv/rpbp_pixel_if.sv */
// Pixel input channel: one framebuffer pixel per transaction.
interface rpbp_pixel_if
  import rpbp_pkg::*;
  ();
  logic   valid;
  logic   ready;
  pixel_t pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

/* sv/rpbp_byte_if.sv */
// Page byte output channel: one packed column byte per transaction.
interface rpbp_byte_if
  import rpbp_pkg::*;
  ();
  logic       valid;
  logic       ready;
  page_byte_t page_byte;
  logic       frame_last;

  modport source (output valid, output page_byte, output frame_last, input ready);
  modport sink   (input valid, input page_byte, input frame_last, output ready);
endinterface

/* sv/rpbp_cfg_if.sv */
// Configuration write channel: register index and write data.
interface rpbp_cfg_if
  import rpbp_pkg::*;
  ();
  logic      valid;
  logic      ready;
  cfg_reg_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/raster_to_page_bitplane_packer.sv */
// Top level of the raster-to-page bitplane packer.
//
//   channel     role    payload                      transaction when
//   pixels      sink    pixel_value[7:0]             valid && ready
//   page_bytes  source  page_byte[7:0], frame_last   valid && ready
//   cfg         sink    index (columns/pages), data  valid && ready
//
// One pixel is taken per clock. Each pixel costs one read-modify-write of its
// column byte in the column memory: read at acceptance, merged and written
// back in the following cycle, with the merged byte forwarded when the next pixel
// hits the same column. Results sit in a four-entry output queue; pixels
// stall only while that queue could overflow. Synchronous reset clears the
// position counters, the pipeline and the queue; the column memory is not
// cleared, since row 0 of every page writes each byte afresh.
module raster_to_page_bitplane_packer
  import rpbp_pkg::*;
#(
  parameter int MAX_COLUMNS = DEFAULT_MAX_COLUMNS,
  parameter int MAX_PAGES   = DEFAULT_MAX_PAGES
) (
  input  logic         clk,
  input  logic         rst,
  rpbp_pixel_if.sink   pixels,
  rpbp_byte_if.source  page_bytes,
  rpbp_cfg_if.sink     cfg
);

  localparam int CW  = $clog2(MAX_COLUMNS);
  localparam int PW  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int RW  = $clog2(ROWS_PER_PAGE);
  localparam int EW  = (CW + 1 > 8) ? CW + 1 : 8;
  localparam int PEW = (PW + 1 > 4) ? PW + 1 : 4;
  localparam int COL_LAST_RESET  =
    ((COLUMNS_RESET < MAX_COLUMNS) ? COLUMNS_RESET : MAX_COLUMNS) - 1;
  localparam int PAGE_LAST_RESET =
    ((PAGES_RESET < MAX_PAGES) ? PAGES_RESET : MAX_PAGES) - 1;
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS_PER_PAGE - 1);

  // Work on the merge stage that follows a pixel acceptance.
  typedef struct packed {
    logic          valid;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic          lit;
    logic          last;
    logic          fwd;
  } merge_t;

  typedef struct packed {
    page_byte_t page_byte;
    logic       frame_last;
  } result_t;

  // Clamped last indexes derived from the registers.
  logic [CW-1:0] col_last;
  logic [PW-1:0] page_last;

  // Position counters.
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_in_page;
  logic [PW-1:0] page_count;

  // Column memory and its registered read port.
  page_byte_t    column_bytes [MAX_COLUMNS];
  page_byte_t    rd_data;

  merge_t        merge;
  page_byte_t    fwd_byte;
  page_byte_t    merged;
  page_byte_t    base;

  // Output queue.
  result_t       queue [4];
  logic [1:0]    head;
  logic [1:0]    tail;
  logic [2:0]    count;
  logic [2:0]    count_push;
  logic          push;
  logic          pop;
  logic          accept;
  logic          last_col;
  logic          last_page;

  logic [EW-1:0]  cols_in;
  logic [PEW-1:0] pages_in;

  // Configuration writes are always taken; limits are stored clamped.
  assign cfg.ready = 1'b1;
  assign cols_in   = EW'(cfg.data);
  assign pages_in  = PEW'(cfg.data[3:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_last  <= CW'(COL_LAST_RESET);
      page_last <= PW'(PAGE_LAST_RESET);
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_COLUMNS: begin
          if (cols_in == '0)
            col_last <= '0;
          else if (cols_in > EW'(MAX_COLUMNS))
            col_last <= CW'(MAX_COLUMNS - 1);
          else
            col_last <= CW'(cols_in - EW'(1));
        end
        CFG_PAGES: begin
          if (pages_in == '0)
            page_last <= '0;
          else if (pages_in > PEW'(MAX_PAGES))
            page_last <= PW'(MAX_PAGES - 1);
          else
            page_last <= PW'(pages_in - PEW'(1));
        end
        default: begin
        end
      endcase
    end
  end

  // Acceptance: stall only when the queue might not hold the next result.
  assign push          = merge.valid && (merge.row == LAST_ROW);
  assign pop           = page_bytes.valid && page_bytes.ready;
  assign count_push    = count + {2'b00, push};
  assign pixels.ready  = (count_push < 3'd4);
  assign accept        = pixels.valid && pixels.ready;
  assign last_col      = (column_count >= col_last);
  assign last_page     = (page_count >= page_last);

  // Raster position counters advance on every accepted pixel.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_in_page  <= '0;
      page_count   <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        if (row_in_page == LAST_ROW) begin
          row_in_page <= '0;
          page_count  <= last_page ? '0 : page_count + PW'(1);
        end else begin
          row_in_page <= row_in_page + RW'(1);
        end
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Merge stage; forward when this pixel hits the column in flight.
  always_ff @(posedge clk) begin
    if (accept) begin
      merge.col  <= column_count;
      merge.row  <= row_in_page;
      merge.lit  <= (pixels.pixel_value != '0);
      merge.last <= last_col && last_page;
      merge.fwd  <= merge.valid && (merge.col == column_count);
    end
    if (rst) begin
      merge.valid <= 1'b0;
    end else begin
      merge.valid <= accept;
    end
  end

  // Column memory read port.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= column_bytes[column_count];
    end
  end

  // Merge the new bit into the column byte; row 0 starts it afresh.
  always_comb begin
    if (merge.row == '0)
      base = '0;
    else if (merge.fwd)
      base = fwd_byte;
    else
      base = rd_data;
    merged = base | (page_byte_t'(merge.lit) << merge.row);
  end

  // Column memory write port and the forwarding copy.
  always_ff @(posedge clk) begin
    if (merge.valid) begin
      column_bytes[merge.col] <= merged;
      fwd_byte                <= merged;
    end
  end

  // Output queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push)
        tail <= tail + 2'd1;
      if (pop)
        head <= head + 2'd1;
      count <= count_push - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[tail] <= '{page_byte: merged, frame_last: merge.last};
    end
  end

  assign page_bytes.valid      = (count != '0);
  assign page_bytes.page_byte  = queue[head].page_byte;
  assign page_bytes.frame_last = queue[head].frame_last;

  // The queue never holds more than its four entries.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("output queue overfilled");

  // A forwarded read only follows a merge in the cycle before.
  a_fwd_source: assert property (@(posedge clk) disable iff (rst)
    (merge.valid && merge.fwd) |-> $past(merge.valid))
    else $error("forwarding without a preceding merge");

  // A pixel on the last row of a page yields a result in the next cycle.
  a_row_emit: assert property (@(posedge clk) disable iff (rst)
    (accept && row_in_page == LAST_ROW) |=> push)
    else $error("page byte not emitted on last row");

  // A write at full queue never happens unless an entry leaves in the same cycle.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (count == 3'd4) |-> !(push && !pop))
    else $error("push into full output queue");

endmodule
